[sv/hsf_pkg.sv]
// Shared types, constants and register codes for the header/sum frame receiver.
`default_nettype none

package hsf_pkg;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  // Frame layout: two header bytes, eighteen body bytes, one sum byte
  localparam int FRAME_BYTES = 21;
  localparam int BODY_BYTES  = 18;
  localparam int COUNT_W     = 5;
  localparam int BODY_IDX_W  = $clog2(BODY_BYTES);

  localparam logic [COUNT_W-1:0] CNT_SECOND_HDR = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] CNT_BODY_FIRST = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] CNT_CHECK      = COUNT_W'(FRAME_BYTES - 1);

  // Byte 3 value that marks the tag as detected
  localparam logic [BYTE_W-1:0] SEEN_CODE = 8'h01;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_HEADER  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_HEADER = CFG_INDEX_W'(1);

  // One decoded frame
  typedef struct packed {
    logic [BYTE_W-1:0] tag_number;
    logic              tag_seen;
    logic [WORD_W-1:0] pos_x_bits;
    logic [WORD_W-1:0] pos_y_bits;
    logic [WORD_W-1:0] pos_z_bits;
    logic [WORD_W-1:0] heading_bits;
  } hsf_result_t;

  // Header match values
  typedef struct packed {
    logic [BYTE_W-1:0] first_header;
    logic [BYTE_W-1:0] second_header;
  } hsf_cfg_t;

endpackage

`default_nettype wire

[sv/hsf_ifs.sv]
// Channel interfaces: received bytes, decoded results and register writes.
`default_nettype none

interface hsf_byte_if import hsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hsf_result_if import hsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tag_number;
  logic              tag_seen;
  logic [WORD_W-1:0] pos_x_bits;
  logic [WORD_W-1:0] pos_y_bits;
  logic [WORD_W-1:0] pos_z_bits;
  logic [WORD_W-1:0] heading_bits;

  modport source (output valid, output tag_number, output tag_seen, output pos_x_bits,
                  output pos_y_bits, output pos_z_bits, output heading_bits, input ready);
  modport sink   (input valid, input tag_number, input tag_seen, input pos_x_bits,
                  input pos_y_bits, input pos_z_bits, input heading_bits, output ready);
endinterface

interface hsf_cfg_if import hsf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/hsf_cfg_regs.sv]
// Header match registers written through the configuration channel.
`default_nettype none

module hsf_cfg_regs import hsf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  hsf_cfg_if.sink   cfg,
  output hsf_cfg_t  regs
);

  hsf_cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign regs      = cfg_q;

  // Decode the index; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FIRST_HEADER:  cfg_q.first_header  <= cfg.data;
        REG_SECOND_HEADER: cfg_q.second_header <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/hsf_frame_parser.sv]
// Frame hunter: header match, body capture, running sum and checksum test.
`default_nettype none

module hsf_frame_parser import hsf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_take,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire hsf_cfg_t          regs,
  output logic                   at_check,
  output logic                   res_load,
  output hsf_result_t            res_data
);

  logic               in_frame, in_frame_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic               store_we;
  logic [BYTE_W-1:0]  payload_store [BODY_BYTES];
  logic [COUNT_W-1:0] body_pos;

  assign at_check = in_frame && (byte_count == CNT_CHECK);
  assign body_pos = byte_count - CNT_BODY_FIRST;

  // Next state for one accepted byte
  always_comb begin
    in_frame_next    = in_frame;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    store_we         = 1'b0;
    res_load         = 1'b0;
    if (byte_take) begin
      if (!in_frame) begin
        if (rx_byte == regs.first_header) begin
          in_frame_next    = 1'b1;
          byte_count_next  = CNT_SECOND_HDR;
          running_sum_next = '0;
        end
      end else if (byte_count == CNT_SECOND_HDR) begin
        if (rx_byte == regs.second_header) begin
          byte_count_next  = CNT_BODY_FIRST;
          running_sum_next = '0;
        end else begin
          in_frame_next    = 1'b0;
          byte_count_next  = '0;
          running_sum_next = '0;
        end
      end else if (byte_count >= CNT_BODY_FIRST && byte_count < CNT_CHECK) begin
        store_we         = 1'b1;
        running_sum_next = running_sum + rx_byte;
        byte_count_next  = byte_count + COUNT_W'(1);
      end else begin
        // checksum byte, or a count that cannot occur: back to hunting
        res_load         = (byte_count == CNT_CHECK) && (rx_byte == running_sum);
        in_frame_next    = 1'b0;
        byte_count_next  = '0;
        running_sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      in_frame    <= in_frame_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // Body bytes 2..19, written in arrival order
  always_ff @(posedge clk) begin
    if (store_we) begin
      payload_store[body_pos[BODY_IDX_W-1:0]] <= rx_byte;
    end
  end

  // Field assembly, words little-endian
  always_comb begin
    res_data.tag_number   = payload_store[0];
    res_data.tag_seen     = (payload_store[1] == SEEN_CODE);
    res_data.pos_x_bits   = {payload_store[5],  payload_store[4],
                             payload_store[3],  payload_store[2]};
    res_data.pos_y_bits   = {payload_store[9],  payload_store[8],
                             payload_store[7],  payload_store[6]};
    res_data.pos_z_bits   = {payload_store[13], payload_store[12],
                             payload_store[11], payload_store[10]};
    res_data.heading_bits = {payload_store[17], payload_store[16],
                             payload_store[15], payload_store[14]};
  end

endmodule

`default_nettype wire

[sv/hsf_result_reg.sv]
// Output register that holds one decoded frame until the receiver takes it.
`default_nettype none

module hsf_result_reg import hsf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_load,
  input  wire hsf_result_t res_data,
  output logic             busy,
  hsf_result_if.source     res
);

  logic        out_valid;
  hsf_result_t out_data;

  // Full and not being drained this cycle
  assign busy = out_valid && !res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res_data;
    end
  end

  assign res.valid        = out_valid;
  assign res.tag_number   = out_data.tag_number;
  assign res.tag_seen     = out_data.tag_seen;
  assign res.pos_x_bits   = out_data.pos_x_bits;
  assign res.pos_y_bits   = out_data.pos_y_bits;
  assign res.pos_z_bits   = out_data.pos_z_bits;
  assign res.heading_bits = out_data.heading_bits;

endmodule

`default_nettype wire

[sv/header_sum_frame_receiver_unit.sv]
// Top level of the header/sum frame receiver.
//
// Channels: rx carries one received serial byte per item; res carries one
// decoded frame (tag number, detected flag, four raw float words); cfg writes
// the two header match registers (index 0 first header, 1 second header,
// other indexes ignored). cfg is always ready.
//
// Throughput: one byte per cycle while rx is ready (see Stall). A frame is
// 21 bytes; the checksum byte ends it. Latency: the result is valid in the
// cycle after the checksum byte is accepted, loaded straight from the body
// store into the output register.
//
// Stall: the output register holds one result. While it is full and res is
// not ready, rx still takes bytes; only a checksum byte waits, since it may
// produce the next result. The ready path is the output register's
// drain condition.
//
// Reset: header registers clear to zero, the parser returns to hunting and
// the output register empties. The body store has no reset.
`default_nettype none

module header_sum_frame_receiver_unit import hsf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  hsf_byte_if.sink     rx,
  hsf_result_if.source res,
  hsf_cfg_if.sink      cfg
);

  hsf_cfg_t    regs;
  hsf_result_t res_data;
  logic        at_check;
  logic        res_load;
  logic        out_busy;
  logic        byte_take;

  // Hold off only the byte that could produce a second pending result
  assign rx.ready  = !(at_check && out_busy);
  assign byte_take = rx.valid && rx.ready;

  hsf_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hsf_frame_parser u_frame_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (rx.rx_byte),
    .regs      (regs),
    .at_check  (at_check),
    .res_load  (res_load),
    .res_data  (res_data)
  );

  hsf_result_reg u_result_reg (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res_data (res_data),
    .busy     (out_busy),
    .res      (res)
  );

endmodule

`default_nettype wire

[tb/tb_header_sum_frame_receiver_unit.sv]
// Self-checking testbench for the header/sum frame receiver: directed frames, then random streams.
module tb_header_sum_frame_receiver_unit;
  import hsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register index outside the decoded range, must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_STRAY = CFG_INDEX_W'(255);
  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_ITEMS   = 250;

  localparam hsf_result_t RES_ZERO = '0;
  localparam hsf_result_t RES_ONES = '{tag_number: 8'hFF, tag_seen: 1'b0,
                                       pos_x_bits: '1, pos_y_bits: '1,
                                       pos_z_bits: '1, heading_bits: '1};

  typedef enum logic [1:0] {ROW_CFG, ROW_FRAME} row_kind_e;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_GIVEN} exp_kind_e;

  // One directed stimulus row: a register write, or optional lead bytes plus a frame
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_INDEX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_val;
    logic [2:0]             n_lead;
    logic [3:0][7:0]        lead;
    logic [7:0]             hdr1;
    logic [7:0]             hdr2;
    logic [7:0]             tag;
    logic [7:0]             seen;
    logic [7:0]             fill;
    logic                   fill_inc;
    logic [7:0]             sum_flip;
    exp_kind_e              exp;
    hsf_result_t            given;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hsf_byte_if   rx_if();
  hsf_result_if res_if();
  hsf_cfg_if    cfg_if();

  header_sum_frame_receiver_unit i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always #2 clk = ~clk;

  // Predicted parser state and header registers
  logic                   exp_in_frame;
  logic [COUNT_W-1:0]     exp_count;
  logic [7:0]             exp_sum;
  logic [7:0]             exp_body [BODY_BYTES];
  logic [7:0]             exp_first_hdr;
  logic [7:0]             exp_second_hdr;

  hsf_result_t frames_due [$];
  stim_row_t   dir_rows [$];

  int  n_err = 0;
  int  n_bytes = 0;
  int  n_checked = 0;
  int  n_bad_sum = 0;
  int  n_hdr_miss = 0;
  int  n_cfg = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;
  bit  calm = 1'b0;
  int  sink_hold = 0;

  // Little-endian word from the body store
  function automatic logic [WORD_W-1:0] body_word(int first);
    body_word = {exp_body[first+3], exp_body[first+2], exp_body[first+1], exp_body[first]};
  endfunction

  // Advance the predicted parser by one byte; returns 1 when a frame decodes
  function automatic bit parse_rx_byte(logic [7:0] b, output hsf_result_t r);
    bit good;
    r = '0;
    parse_rx_byte = 1'b0;
    if (!exp_in_frame) begin
      if (b == exp_first_hdr) begin
        exp_in_frame = 1'b1;
        exp_count    = CNT_SECOND_HDR;
        exp_sum      = '0;
      end
    end else if (exp_count == CNT_SECOND_HDR) begin
      if (b != exp_second_hdr) begin
        exp_in_frame = 1'b0;
        exp_count    = '0;
      end else begin
        exp_count = CNT_BODY_FIRST;
      end
      exp_sum = '0;
    end else if (exp_count >= CNT_BODY_FIRST && exp_count < CNT_CHECK) begin
      exp_body[exp_count - CNT_BODY_FIRST] = b;
      exp_sum   = exp_sum + b;
      exp_count = exp_count + 1'b1;
    end else begin
      // checksum byte, or a count that cannot occur: back to hunting either way
      good = (exp_count == CNT_CHECK) && (b == exp_sum);
      exp_in_frame = 1'b0;
      exp_count    = '0;
      exp_sum      = '0;
      if (good) begin
        r.tag_number   = exp_body[0];
        r.tag_seen     = (exp_body[1] == SEEN_CODE);
        r.pos_x_bits   = body_word(2);
        r.pos_y_bits   = body_word(6);
        r.pos_z_bits   = body_word(10);
        r.heading_bits = body_word(14);
        parse_rx_byte  = 1'b1;
      end
    end
  endfunction

  function automatic logic [17:0][7:0] make_body(logic [7:0] tag, logic [7:0] seen,
                                                 logic [7:0] fill, logic inc);
    make_body[0] = tag;
    make_body[1] = seen;
    for (int i = 2; i < BODY_BYTES; i++) make_body[i] = inc ? fill + 8'(i) : fill;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
    cfg_row = '0;
    cfg_row.kind    = ROW_CFG;
    cfg_row.cfg_idx = idx;
    cfg_row.cfg_val = val;
  endfunction

  function automatic stim_row_t frame_row(logic [2:0] n_lead, logic [3:0][7:0] lead,
                                          logic [7:0] h1, logic [7:0] h2, logic [7:0] tag,
                                          logic [7:0] seen, logic [7:0] fill, logic inc,
                                          logic [7:0] flip, exp_kind_e exp,
                                          hsf_result_t given);
    frame_row = '{kind: ROW_FRAME, cfg_idx: '0, cfg_val: '0, n_lead: n_lead, lead: lead,
                  hdr1: h1, hdr2: h2, tag: tag, seen: seen, fill: fill, fill_inc: inc,
                  sum_flip: flip, exp: exp, given: given};
  endfunction

  // Send one byte at the falling edge, wait for acceptance, update the prediction
  task automatic send_byte(logic [7:0] b, bit use_pred);
    hsf_result_t r;
    if (src_idle_on && !calm && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    n_bytes++;
    if (parse_rx_byte(b, r) && use_pred) frames_due.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_frame(logic [7:0] h1, logic [7:0] h2, logic [17:0][7:0] body,
                            logic [7:0] flip, bit use_pred);
    logic [7:0] sum;
    sum = '0;
    send_byte(h1, use_pred);
    send_byte(h2, use_pred);
    for (int i = 0; i < BODY_BYTES; i++) begin
      sum = sum + body[i];
      send_byte(body[i], use_pred);
    end
    send_byte(sum ^ flip, use_pred);
    if (flip != 0) n_bad_sum++;
  endtask

  // Stop sending and let every expected frame drain out
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == REG_FIRST_HEADER) exp_first_hdr = val;
    else if (idx == REG_SECOND_HEADER) exp_second_hdr = val;
    n_cfg++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    // an idle gap so a following write starts on a later edge
    @(negedge clk);
  endtask

  // Body byte for random frames, sometimes a header value to test no-resync
  function automatic logic [7:0] rand_body_byte(logic [7:0] h1, logic [7:0] h2);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return h1;
    if (pick == 1) return h2;
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random ready bursts, none in the calm tail
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      res_if.ready <= 1'b0;
    end else if (sink_idle_on && !calm && $urandom_range(0, 4) == 0) begin
      sink_hold = $urandom_range(0, 3);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare each accepted frame against the oldest expectation
  always @(posedge clk) begin : check_res
    hsf_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected result: tag_number %0h", res_if.tag_number);
        n_err++;
      end else begin
        want = frames_due.pop_front();
        n_checked++;
        if (res_if.tag_number !== want.tag_number) begin
          $error("tag_number: expected %0h, got %0h", want.tag_number, res_if.tag_number);
          n_err++;
        end
        if (res_if.tag_seen !== want.tag_seen) begin
          $error("tag_seen: expected %0b, got %0b", want.tag_seen, res_if.tag_seen);
          n_err++;
        end
        if (res_if.pos_x_bits !== want.pos_x_bits) begin
          $error("pos_x_bits: expected %08h, got %08h", want.pos_x_bits, res_if.pos_x_bits);
          n_err++;
        end
        if (res_if.pos_y_bits !== want.pos_y_bits) begin
          $error("pos_y_bits: expected %08h, got %08h", want.pos_y_bits, res_if.pos_y_bits);
          n_err++;
        end
        if (res_if.pos_z_bits !== want.pos_z_bits) begin
          $error("pos_z_bits: expected %08h, got %08h", want.pos_z_bits, res_if.pos_z_bits);
          n_err++;
        end
        if (res_if.heading_bits !== want.heading_bits) begin
          $error("heading_bits: expected %08h, got %08h", want.heading_bits,
                 res_if.heading_bits);
          n_err++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("** header_sum_frame_receiver_unit: FAILED **");
    $finish;
  end

  // Main sequence
  initial begin : main
    stim_row_t        row;
    logic [17:0][7:0] body;
    logic [7:0]       h1;
    logic [7:0]       h2;
    int               items;
    int               kind;
    int               phase_end;

    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;

    exp_in_frame   = 1'b0;
    exp_count      = '0;
    exp_sum        = '0;
    exp_first_hdr  = '0;
    exp_second_hdr = '0;
    for (int i = 0; i < BODY_BYTES; i++) exp_body[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    // reset headers are zero: all-zero frame, all-ones frame, bad sum
    dir_rows.push_back(frame_row(0, '0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 8'h00,
                                 EXP_GIVEN, RES_ZERO));
    dir_rows.push_back(frame_row(0, '0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 0, 8'h00,
                                 EXP_GIVEN, RES_ONES));
    dir_rows.push_back(frame_row(0, '0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 0, 8'h80,
                                 EXP_NONE, RES_ZERO));
    dir_rows.push_back(cfg_row(REG_FIRST_HEADER, 8'hFF));
    dir_rows.push_back(cfg_row(REG_SECOND_HEADER, 8'hFF));
    // header bytes must stay out of the sum
    dir_rows.push_back(frame_row(0, '0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 0, 8'h00,
                                 EXP_GIVEN, RES_ZERO));
    // write beyond the register range is ignored
    dir_rows.push_back(cfg_row(REG_STRAY, 8'h00));
    dir_rows.push_back(frame_row(0, '0, 8'hFF, 8'hFF, 8'h7F, SEEN_CODE, 8'h10, 1, 8'h00,
                                 EXP_PREDICT, RES_ZERO));
    dir_rows.push_back(cfg_row(REG_FIRST_HEADER, 8'hA5));
    dir_rows.push_back(cfg_row(REG_SECOND_HEADER, 8'h5A));
    // second header miss on a repeated first header, then a frame full of header values
    dir_rows.push_back(frame_row(3, {8'h00, 8'h5A, 8'hA5, 8'hA5}, 8'hA5, 8'h5A, 8'h5A,
                                 8'hA5, 8'hA5, 0, 8'h00, EXP_PREDICT, RES_ZERO));
    dir_rows.push_back(frame_row(2, {16'h0000, 8'h00, 8'hA5}, 8'hA5, 8'h5A, 8'h01,
                                 8'h02, 8'hC3, 1, 8'h00, EXP_PREDICT, RES_ZERO));
    dir_rows.push_back(frame_row(0, '0, 8'hA5, 8'h5A, 8'h80, SEEN_CODE, 8'h7E, 1, 8'h01,
                                 EXP_NONE, RES_ZERO));
    dir_rows.push_back(cfg_row(REG_FIRST_HEADER, 8'h00));
    dir_rows.push_back(frame_row(1, {24'h0, 8'hA5}, 8'h00, 8'h5A, 8'h00, SEEN_CODE, 8'hF0,
                                 1, 8'h00, EXP_PREDICT, RES_ZERO));

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        for (int k = 0; k < row.n_lead; k++) send_byte(row.lead[k], 1'b1);
        body = make_body(row.tag, row.seen, row.fill, row.fill_inc);
        send_frame(row.hdr1, row.hdr2, body, row.sum_flip, row.exp == EXP_PREDICT);
        if (row.exp == EXP_GIVEN) frames_due.push_back(row.given);
      end
    end

    // Random part: phases with different header settings
    items = 0;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin h1 = 8'hFF; h2 = 8'h00; end
        1: begin h1 = 8'h00; h2 = 8'hFF; end
        3: begin h1 = 8'($urandom_range(0, 255)); h2 = h1; end
        default: begin
          h1 = 8'($urandom_range(0, 255));
          h2 = 8'($urandom_range(0, 255));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_SECOND_HEADER, h2);
        write_reg(REG_FIRST_HEADER, h1);
      end else begin
        write_reg(REG_FIRST_HEADER, h1);
        write_reg(REG_SECOND_HEADER, h2);
      end
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));

      phase_end = (phase + 1) * RANDOM_ITEMS / 6;
      while (items < phase_end) begin
        calm = (items >= RANDOM_ITEMS - CALM_ITEMS);
        src_idle_on  = ($urandom_range(0, 9) < 7);
        sink_idle_on = ($urandom_range(0, 9) < 7);
        // hold the sender until every frame has drained
        if ($urandom_range(0, 29) == 0) wait_idle();
        // occasional noise while hunting
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b1);
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          for (int i = 0; i < BODY_BYTES; i++) body[i] = rand_body_byte(h1, h2);
          if ($urandom_range(0, 2) == 0) body[1] = SEEN_CODE;
          send_frame(h1, h2, body, (kind < 65) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b1);
          items += FRAME_BYTES;
        end else if (kind < 92) begin
          send_byte(h1, 1'b1);
          send_byte(h2 ^ 8'($urandom_range(1, 255)), 1'b1);
          n_hdr_miss++;
          items += 2;
        end else begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
      end
    end

    // Drain and settle
    rx_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Run covered %0d bytes, %0d register writes, %0d frames checked,",
             n_bytes, n_cfg, n_checked);
    $display("  %0d frames with a corrupt sum and %0d second header misses.",
             n_bad_sum, n_hdr_miss);
    if (n_err == 0 && frames_due.size() == 0) begin
      $display("** header_sum_frame_receiver_unit: PASSED **");
    end else begin
      $display("** header_sum_frame_receiver_unit: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/hsf_pkg.sv
sv/hsf_ifs.sv
sv/hsf_cfg_regs.sv
sv/hsf_frame_parser.sv
sv/hsf_result_reg.sv
sv/header_sum_frame_receiver_unit.sv
tb/tb_header_sum_frame_receiver_unit.sv
